### rtl/bcba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcba_pkg;

   // Map geometry: one used bit per block, packed into 32-bit memory words.
   localparam int NUM_BLOCKS  = 1024;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = NUM_BLOCKS / WORD_BITS;
   localparam int WORD_ADDR_W = $clog2(MAP_WORDS);
   localparam int BIT_SEL_W   = $clog2(WORD_BITS);
   localparam int BLK_IDX_W   = $clog2(NUM_BLOCKS);

   // The run search looks at one chunk of a word per cycle.
   localparam int CHUNK_BITS  = 8;
   localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;
   localparam int CHUNK_SEL_W = $clog2(CHUNKS);
   localparam int CHUNK_POS_W = $clog2(CHUNK_BITS);

   // Field widths.
   localparam int CNT_W   = 11;
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 32;
   localparam int STAT_W  = 3;
   localparam int LOG2_W  = 5;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_TOO_FEW    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_RUN     = 3'd2;
   localparam logic [STAT_W-1:0] ST_BELOW_BASE = 3'd3;
   localparam logic [STAT_W-1:0] ST_BEYOND_END = 3'd4;

   // Request operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Configuration register indexes. The spare index holds no register and
   // writes to it are ignored.
   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_LOG2  = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;
   localparam logic [1:0] REG_SPARE = 2'd3;

   // Inputs to the run search for one chunk.
   typedef struct packed {
      logic [CHUNK_BITS-1:0] used_bits;
      logic [BLK_IDX_W-1:0]  first_index;
      logic [CNT_W-1:0]      run_in;
      logic [CNT_W-1:0]      need;
      logic [CNT_W-1:0]      limit;
   } scan_in_type;

   // Outcome of the run search for one chunk.
   typedef struct packed {
      logic                 hit;
      logic [BLK_IDX_W-1:0] start;
      logic [CNT_W-1:0]     run_out;
   } scan_out_type;

endpackage

`default_nettype wire

### rtl/bitmap_contiguous_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         tvalid/tready         tuser operation, tdata size and address
// rsp_      out        tvalid/tready         tdata address, status, free count
// csr_      in         APB, pready tied high 64-bit registers at 0x00, 0x08, 0x10
//
// One request at a time. An allocate searches the map one 8-bit chunk per cycle
// (up to 32 words), then marks each word of the run found in turn. A free
// checks the address and then clears each word of its run in turn. Reset and
// every write to a register other than the spare index start a clearing pass
// over all 32 words of the map memory, during which no request is accepted. A
// result waits in the output register while the next request is taken.

module bitmap_contiguous_block_allocator
   import bcba_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tuser: operation [0]
   // req_tdata: request_size [31:0], free_address [95:32]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,
   input  wire logic         req_tuser,
   // rsp_tdata: result_address [63:0], status [66:64], free_count_now [77:67]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_CHECK, S_SCAN, S_MARK, S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LOG2_W-1:0] log2_ff, log2_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  eff_cnt, eff_cnt_in;
   logic              cfg_wr;
   logic [1:0]        cfg_idx;

   // Request and working registers.
   logic              op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [SIZE_W:0]   blocks_ff, blocks_in;
   logic [ADDR_W-1:0] diff_ff, diff_in;
   logic              below_ff, below_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  fcount_ff, fcount_in;
   logic [WORD_ADDR_W-1:0] word_ff, word_in;
   logic [CHUNK_SEL_W-1:0] chunk_ff, chunk_in;
   logic [BLK_IDX_W-1:0]   lo_ff, lo_in;
   logic [WORD_ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [79:0]       out_data_ff, out_data_in;

   // Map memory port signals.
   logic                   mem_wr_en;
   logic [WORD_ADDR_W-1:0] mem_wr_addr;
   logic [WORD_BITS-1:0]   mem_wr_data;
   logic                   mem_rd_en;
   logic [WORD_ADDR_W-1:0] mem_rd_addr;
   logic [WORD_BITS-1:0]   mem_rd_data;

   scan_in_type  scan_in;
   scan_out_type scan_out;

   bcba_map_store u_map_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bcba_run_scan u_run_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   // Register port decode and read back.
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[4:3];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (cfg_idx)
         REG_BASE:  csr_prdata = base_ff;
         REG_LOG2:  csr_prdata = {59'd0, log2_ff};
         REG_COUNT: csr_prdata = {53'd0, count_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign eff_cnt    = (count_ff > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : count_ff;
   assign eff_cnt_in = (count_in > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : count_in;

   // Run search input: the current chunk of the word just read.
   always_comb begin
      scan_in.used_bits   = mem_rd_data[chunk_ff*CHUNK_BITS +: CHUNK_BITS];
      scan_in.first_index = {word_ff, chunk_ff, CHUNK_POS_W'(0)};
      scan_in.run_in      = run_ff;
      scan_in.need        = need_ff;
      scan_in.limit       = eff_cnt;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Control sequencer next-state logic.
   always_comb begin
      logic [SIZE_W:0]      bs_m1;
      logic [ADDR_W-1:0]    start64;
      logic [ADDR_W-1:0]    cnt64;
      logic [ADDR_W-1:0]    blk64;
      logic [CNT_W-1:0]     hi_calc;
      logic [CNT_W:0]       fsum;
      logic [WORD_BITS-1:0] mask;
      logic [BLK_IDX_W-1:0] bidx;
      state_in    = state_ff;
      base_in     = base_ff;
      log2_in     = log2_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      faddr_in    = faddr_ff;
      blocks_in   = blocks_ff;
      diff_in     = diff_ff;
      below_in    = below_ff;
      need_in     = need_ff;
      run_in      = run_ff;
      fcount_in   = fcount_ff;
      word_in     = word_ff;
      chunk_in    = chunk_ff;
      lo_in       = lo_ff;
      clr_in      = clr_ff;
      res_addr_in = res_addr_ff;
      res_stat_in = res_stat_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = word_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = word_ff;
      bs_m1   = (SIZE_W+1)'(1) << log2_ff;
      bs_m1   = bs_m1 - (SIZE_W+1)'(1);
      start64 = diff_ff >> log2_ff;
      cnt64   = {{(ADDR_W-CNT_W){1'b0}}, eff_cnt};
      blk64   = {{(ADDR_W-SIZE_W-1){1'b0}}, blocks_ff};
      hi_calc = {1'b0, lo_ff} + need_ff - CNT_W'(1);
      fsum    = {1'b0, fcount_ff} + {1'b0, need_ff};
      mask    = '0;
      bidx    = '0;

      // The result leaves the output register when taken.
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + WORD_ADDR_W'(1);
            if (clr_ff == WORD_ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               size_in  = req_tdata[31:0];
               faddr_in = req_tdata[95:32];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // Round the byte size up to whole blocks; start the address checks.
            blocks_in = ({1'b0, size_ff} + bs_m1) >> log2_ff;
            below_in  = faddr_ff < base_ff;
            diff_in   = faddr_ff - base_ff;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            res_addr_in = '0;
            res_stat_in = ST_OK;
            if (op_ff == OP_ALLOC) begin
               res_addr_in = '1;
               // A zero-byte allocate still needs one free block.
               if (blocks_ff > {{(SIZE_W+1-CNT_W){1'b0}}, fcount_ff} ||
                   (blocks_ff == '0 && fcount_ff == '0)) begin
                  res_stat_in = ST_TOO_FEW;
                  state_in    = S_RESP;
               end else begin
                  need_in   = (blocks_ff == '0) ? CNT_W'(1) : blocks_ff[CNT_W-1:0];
                  run_in    = '0;
                  word_in   = '0;
                  chunk_in  = '0;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in  = S_SCAN;
               end
            end else begin
               if (below_ff) begin
                  res_stat_in = ST_BELOW_BASE;
                  state_in    = S_RESP;
               end else if (blk64 > cnt64 || start64 > cnt64 - blk64) begin
                  res_stat_in = ST_BEYOND_END;
                  state_in    = S_RESP;
               end else if (blocks_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  need_in     = blocks_ff[CNT_W-1:0];
                  lo_in       = start64[BLK_IDX_W-1:0];
                  word_in     = start64[BLK_IDX_W-1:BIT_SEL_W];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = start64[BLK_IDX_W-1:BIT_SEL_W];
                  state_in    = S_MARK;
               end
            end
         end
         S_SCAN: begin
            if (scan_out.hit) begin
               lo_in       = scan_out.start;
               word_in     = scan_out.start[BLK_IDX_W-1:BIT_SEL_W];
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_out.start[BLK_IDX_W-1:BIT_SEL_W];
               state_in    = S_MARK;
            end else begin
               run_in   = scan_out.run_out;
               chunk_in = chunk_ff + CHUNK_SEL_W'(1);
               if (chunk_ff == CHUNK_SEL_W'(CHUNKS - 1)) begin
                  if (word_ff == WORD_ADDR_W'(MAP_WORDS - 1)) begin
                     res_stat_in = ST_NO_RUN;
                     state_in    = S_RESP;
                  end else begin
                     word_in     = word_ff + WORD_ADDR_W'(1);
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = word_ff + WORD_ADDR_W'(1);
                  end
               end
            end
         end
         S_MARK: begin
            // Read-modify-write one word a cycle; the next word's read overlaps.
            for (int b = 0; b < WORD_BITS; b++) begin
               bidx    = {word_ff, BIT_SEL_W'(b)};
               mask[b] = (bidx >= lo_ff) && (bidx <= hi_calc[BLK_IDX_W-1:0]);
            end
            mem_wr_en   = 1'b1;
            mem_wr_addr = word_ff;
            mem_wr_data = (op_ff == OP_ALLOC) ? (mem_rd_data | mask)
                                              : (mem_rd_data & ~mask);
            if (word_ff == hi_calc[BLK_IDX_W-1:BIT_SEL_W]) begin
               if (op_ff == OP_ALLOC) begin
                  fcount_in   = fcount_ff - need_ff;
                  res_addr_in = base_ff +
                                ({{(ADDR_W-BLK_IDX_W){1'b0}}, lo_ff} << log2_ff);
                  res_stat_in = ST_OK;
               end else begin
                  fcount_in = (fsum > {1'b0, eff_cnt}) ? eff_cnt : fsum[CNT_W-1:0];
               end
               state_in = S_RESP;
            end else begin
               word_in     = word_ff + WORD_ADDR_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = word_ff + WORD_ADDR_W'(1);
            end
         end
         S_RESP: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {2'b00, fcount_ff, res_stat_ff, res_addr_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // A write to any register but the spare index reinitialises the store.
      if (cfg_wr) begin
         case (cfg_idx)
            REG_BASE:  base_in  = csr_pwdata;
            REG_LOG2:  log2_in  = csr_pwdata[LOG2_W-1:0];
            REG_COUNT: count_in = csr_pwdata[CNT_W-1:0];
            default:   ;
         endcase
         if (cfg_idx != REG_SPARE) begin
            state_in  = S_CLEAR;
            clr_in    = '0;
            fcount_in = eff_cnt_in;
         end
      end
   end

   // State, control and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         log2_ff      <= LOG2_W'(6);
         count_ff     <= CNT_W'(NUM_BLOCKS);
         fcount_ff    <= CNT_W'(NUM_BLOCKS);
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         log2_ff      <= log2_in;
         count_ff     <= count_in;
         fcount_ff    <= fcount_in;
         out_valid_ff <= out_valid_in;
         out_data_ff  <= out_data_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      faddr_ff    <= faddr_in;
      blocks_ff   <= blocks_in;
      diff_ff     <= diff_in;
      below_ff    <= below_in;
      need_ff     <= need_in;
      run_ff      <= run_in;
      word_ff     <= word_in;
      chunk_ff    <= chunk_in;
      lo_ff       <= lo_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
   end

   // The free count never exceeds the managed block count.
   assert property (@(posedge clock) disable iff (reset) fcount_ff <= eff_cnt)
      else $error("free count above block count");

   // The map is never read and written at the same row in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && mem_wr_addr == mem_rd_addr))
      else $error("map read and write collide");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !cfg_wr) |=> !req_tready)
      else $error("request taken while busy");

   // A delivered status is always a defined code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[66:64] <= ST_BEYOND_END))
      else $error("undefined status code");

endmodule

`default_nettype wire

### rtl/bcba_map_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bcba_map_store
   import bcba_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [WORD_ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_BITS-1:0]   wr_data,
   input  wire logic                   rd_en,
   input  wire logic [WORD_ADDR_W-1:0] rd_addr,
   output logic      [WORD_BITS-1:0]   rd_data
);

   // Used-bit map, one word per row.
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, data valid the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/bcba_run_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module bcba_run_scan
   import bcba_pkg::*;
(
   input  wire scan_in_type  scan_in,
   output scan_out_type      scan_out
);

   // Walk one chunk, extending the current run of free blocks. Blocks at or
   // beyond the managed count are treated as used.
   always_comb begin
      logic [CNT_W-1:0]     run;
      logic                 hit;
      logic [BLK_IDX_W-1:0] start;
      logic [BLK_IDX_W-1:0] idx;
      logic [CNT_W-1:0]     begin_idx;
      run       = scan_in.run_in;
      hit       = 1'b0;
      start     = '0;
      idx       = '0;
      begin_idx = '0;
      for (int j = 0; j < CHUNK_BITS; j++) begin
         idx = scan_in.first_index + BLK_IDX_W'(j);
         if (!scan_in.used_bits[j] && ({1'b0, idx} < scan_in.limit)) begin
            run = run + CNT_W'(1);
         end else begin
            run = '0;
         end
         if (!hit && run == scan_in.need) begin
            hit       = 1'b1;
            begin_idx = {1'b0, idx} + CNT_W'(1) - scan_in.need;
            start     = begin_idx[BLK_IDX_W-1:0];
         end
      end
      scan_out.hit     = hit;
      scan_out.start   = start;
      scan_out.run_out = run;
   end

endmodule

`default_nettype wire
